### sv/permutation_enumerator_top_macros.svh
// Assertion macros shared by the permutation enumerator RTL.
`ifndef PERMUTATION_ENUMERATOR_TOP_MACROS_SVH
`define PERMUTATION_ENUMERATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/perm_enum_pkg.sv
// Shared types and constants of the permutation enumerator.
`timescale 1ns / 1ps
package perm_enum_pkg;

  localparam int LEN_W        = 4;
  localparam int VAL_W        = 4;
  localparam int POS_W        = 3;
  localparam int RESULT_LIMIT = 8;
  localparam int LEN_RESET    = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic step;
    logic emit;
    logic emit_done;
  } pe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exhaust;
    logic to_check;
    logic has_repeat;
    logic emit_last;
  } pe_sts_t;

endpackage

### sv/perm_enum_in_if.sv
// Request channel: valid/ready handshake carrying the restart flag.
`timescale 1ns / 1ps
interface perm_enum_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

### sv/perm_enum_out_if.sv
// Result channel: valid/ready handshake carrying one permutation element.
`timescale 1ns / 1ps
interface perm_enum_out_if;
  import perm_enum_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] elem_value;
  logic [POS_W-1:0] elem_pos;
  logic             last_elem;
  logic             exhausted;

  modport source (output valid, output elem_value, output elem_pos, output last_elem,
                  output exhausted, input ready);
  modport sink (input valid, input elem_value, input elem_pos, input last_elem,
                input exhausted, output ready);
endinterface

### sv/perm_enum_ctrl.sv
// Controller state machine of the permutation enumerator.
`timescale 1ns / 1ps
`include "permutation_enumerator_top_macros.svh"
module perm_enum_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output perm_enum_pkg::pe_cmd_t cmd_o,
  input  perm_enum_pkg::pe_sts_t sts_i
);
  import perm_enum_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STEP   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_EMIT   = 5'b01000,
    S_FINISH = 5'b10000
  } pe_state_e;

  pe_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      accept;
  logic      slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          state_d     = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.exhaust) begin
          state_d = S_FINISH;
        end else if (sts_i.to_check) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = sts_i.has_repeat ? S_STEP : S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit || cmd_o.emit_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Values do not change between a passed check and the last emitted element.
  `PE_ASSERT_IMP(a_emit_no_repeat, clk_i, rst_ni, state_q == S_EMIT, !sts_i.has_repeat, "repeat seen while emitting")
  // A beat is only loaded into the output slot when the slot can take it.
  `PE_ASSERT_IMP(a_load_slot_free, clk_i, rst_ni, cmd_o.emit || cmd_o.emit_done, !out_valid_q || out_ready_i, "output slot overwritten")

endmodule

### sv/perm_enum_dp.sv
// Datapath of the permutation enumerator: position values, depth, checks, output slot.
`timescale 1ns / 1ps
`include "permutation_enumerator_top_macros.svh"
module perm_enum_dp #(
  parameter int MAX_N = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [perm_enum_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  logic                               restart_i,
  input  perm_enum_pkg::pe_cmd_t             cmd_i,
  output perm_enum_pkg::pe_sts_t             sts_o,
  output logic [perm_enum_pkg::VAL_W-1:0]    elem_value_o,
  output logic [perm_enum_pkg::POS_W-1:0]    elem_pos_o,
  output logic                               last_elem_o,
  output logic                               exhausted_o
);
  import perm_enum_pkg::*;

  localparam int LIM     = (MAX_N < RESULT_LIMIT) ? MAX_N : RESULT_LIMIT;
  localparam int IW      = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int LEN_RST = (LEN_RESET > LIM) ? LIM : LEN_RESET;

  localparam logic [LEN_W-1:0] LimLen = LEN_W'(LIM);
  localparam logic [LEN_W-1:0] RstLen = LEN_W'(LEN_RST);

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] len_cfg;
  logic [VAL_W-1:0] val_q [LIM];
  logic [IW-1:0]    depth_q;
  logic [IW-1:0]    idx_q;
  logic             done_q;

  logic [LEN_W-1:0] last_w;
  logic [IW-1:0]    last_idx;
  logic [IW-1:0]    rd_idx;
  logic [VAL_W-1:0] rd_val;
  logic             can_inc;
  logic             at_last;
  logic             has_rep;

  logic [VAL_W-1:0] elem_value_q;
  logic [POS_W-1:0] elem_pos_q;
  logic             last_elem_q;
  logic             exhausted_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_cfg = LEN_W'(1);
    end else if (cfg_wdata_i > LimLen) begin
      len_cfg = LimLen;
    end else begin
      len_cfg = cfg_wdata_i;
    end
  end

  assign last_w   = len_q - LEN_W'(1);
  assign last_idx = last_w[IW-1:0];

  // One read port: the emit counter while emitting, the search depth otherwise.
  assign rd_idx  = cmd_i.emit ? idx_q : depth_q;
  assign rd_val  = val_q[rd_idx];
  assign can_inc = (LEN_W'(rd_val) < len_q);
  assign at_last = (depth_q == last_idx);

  always_comb begin
    has_rep = 1'b0;
    for (int i = 1; i < LIM; i++) begin
      for (int j = 0; j < i; j++) begin
        if ((LEN_W'(i) < len_q) && (val_q[i] == val_q[j])) begin
          has_rep = 1'b1;
        end
      end
    end
  end

  assign sts_o.exhaust    = done_q || (!can_inc && (depth_q == '0));
  assign sts_o.to_check   = !done_q && can_inc && at_last;
  assign sts_o.has_repeat = has_rep;
  assign sts_o.emit_last  = (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= RstLen;
      depth_q <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < LIM; i++) begin
        val_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i || (cmd_i.start && restart_i)) begin
        if (cfg_we_i) begin
          len_q <= len_cfg;
        end
        depth_q <= '0;
        done_q  <= 1'b0;
        for (int i = 0; i < LIM; i++) begin
          val_q[i] <= '0;
        end
      end else if (cmd_i.step && !done_q) begin
        if (can_inc) begin
          val_q[depth_q] <= rd_val + VAL_W'(1);
          if (!at_last) begin
            depth_q <= depth_q + IW'(1);
          end
        end else if (depth_q == '0) begin
          done_q <= 1'b1;
        end else begin
          // Backing out clears the position so a later descent finds it at zero.
          val_q[depth_q] <= '0;
          depth_q        <= depth_q - IW'(1);
        end
      end
      if (cmd_i.step) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      elem_value_q <= rd_val;
      elem_pos_q   <= POS_W'(idx_q);
      last_elem_q  <= (idx_q == last_idx);
      exhausted_q  <= 1'b0;
    end else if (cmd_i.emit_done) begin
      elem_value_q <= '0;
      elem_pos_q   <= '0;
      last_elem_q  <= 1'b1;
      exhausted_q  <= 1'b1;
    end
  end

  assign elem_value_o = elem_value_q;
  assign elem_pos_o   = elem_pos_q;
  assign last_elem_o  = last_elem_q;
  assign exhausted_o  = exhausted_q;

  `PE_ASSERT(a_depth_in_range, clk_i, rst_ni, LEN_W'(depth_q) <= last_w, "depth beyond last position")
  `PE_ASSERT_IMP(a_value_bounded, clk_i, rst_ni, cmd_i.step, LEN_W'(rd_val) <= len_q, "position value above length")
  `PE_ASSERT_NXT(a_done_sticky, clk_i, rst_ni, done_q && !cfg_we_i && !(cmd_i.start && restart_i), done_q, "done flag dropped without restart")

endmodule

### sv/permutation_enumerator_top.sv
// Top level of the permutation enumerator: controller, datapath and channel wiring.
// A request is accepted in idle, then the search steps run with a duplicate check for each
// full-length candidate, then n result beats (one beat when exhausted) follow, 1 per cycle
// while ready. Throughput is set by the backtracking step loop; one request is in work at a time.
// Reset (rst_ni low, asynchronous) sets length 3, clears all positions, depth and done.
`timescale 1ns / 1ps
module permutation_enumerator_top #(
  parameter int MAX_N = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [perm_enum_pkg::LEN_W-1:0] cfg_wdata_i,
  perm_enum_in_if.sink                    req_i,
  perm_enum_out_if.source                 rsp_o
);
  import perm_enum_pkg::*;

  // The controller sequences each request: it accepts a beat, drives the search one
  // step per cycle, enters the check state for the duplicate check whenever the last
  // position holds a fresh candidate, and then streams the elements out.
  pe_cmd_t cmd;
  pe_sts_t sts;

  perm_enum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath keeps the per-position values, the depth, the done flag and the
  // registered output slot. The slot lets the controller go back to idle and take
  // the next request while the final beat of the previous one still waits.
  // A length write restarts the search, so stored values always stay within 0..n.
  perm_enum_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .restart_i    (req_i.restart),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .elem_value_o (rsp_o.elem_value),
    .elem_pos_o   (rsp_o.elem_pos),
    .last_elem_o  (rsp_o.last_elem),
    .exhausted_o  (rsp_o.exhausted)
  );

endmodule

### test/permutation_enumerator_checker.sv
// Checker for the permutation enumerator: watches both channels, predicts each beat and compares.
`timescale 1ns / 1ps
module permutation_enumerator_checker #(
  parameter int MAX_N = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [perm_enum_pkg::LEN_W-1:0] cfg_wdata_i,
  perm_enum_in_if                         req_i,
  perm_enum_out_if                        rsp_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);
  import perm_enum_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             exh;
  } elem_beat_t;

  elem_beat_t       beat_q[$];
  logic [LEN_W-1:0] len_reg;
  logic [VAL_W-1:0] place_val[MAX_N];
  logic [3:0]       depth;
  logic             search_over;
  int               fails;

  function automatic void clear_search();
    foreach (place_val[i]) place_val[i] = '0;
    depth       = '0;
    search_over = 1'b0;
  endfunction

  // Runs the backtracking search up to the next permutation and queues its beats,
  // or queues a single done beat once every permutation has been produced.
  function automatic void find_next_permutation(input logic restart_req);
    int unsigned n;
    int unsigned k;
    bit          dup;
    elem_beat_t  b;
    n = 32'(len_reg);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    if (n > RESULT_LIMIT) n = RESULT_LIMIT;
    if (restart_req) clear_search();
    if (32'(depth) > n - 1) depth = 4'(n - 1);
    while (!search_over) begin
      k = 32'(depth);
      if (place_val[k] < n) begin
        place_val[k] = place_val[k] + 1'b1;
        if (k == n - 1) begin
          dup = 1'b0;
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < i; j++) begin
              if (place_val[i] == place_val[j]) dup = 1'b1;
            end
          end
          if (!dup) begin
            for (int i = 0; i < n; i++) begin
              b.value = place_val[i];
              b.pos   = POS_W'(i);
              b.last  = (i == n - 1);
              b.exh   = 1'b0;
              beat_q.push_back(b);
            end
            return;
          end
        end else begin
          depth            = 4'(k + 1);
          place_val[k + 1] = '0;
        end
      end else if (k == 0) begin
        search_over = 1'b1;
      end else begin
        depth = 4'(k - 1);
      end
    end
    b.value = '0;
    b.pos   = '0;
    b.last  = 1'b1;
    b.exh   = 1'b1;
    beat_q.push_back(b);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    elem_beat_t want;
    if (!rst_ni) begin
      len_reg = LEN_W'(LEN_RESET);
      clear_search();
      beat_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        len_reg = cfg_wdata_i;
        clear_search();
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (beat_q.size() == 0) begin
          $error("unexpected result beat: value %0d pos %0d last %0b exhausted %0b",
                 rsp_i.elem_value, rsp_i.elem_pos, rsp_i.last_elem, rsp_i.exhausted);
          fails++;
        end else begin
          want = beat_q.pop_front();
          check_field("elem_value", 8'(want.value), 8'(rsp_i.elem_value));
          check_field("elem_pos", 8'(want.pos), 8'(rsp_i.elem_pos));
          check_field("last_elem", 8'(want.last), 8'(rsp_i.last_elem));
          check_field("exhausted", 8'(want.exh), 8'(rsp_i.exhausted));
        end
      end
      if (req_i.valid && req_i.ready) find_next_permutation(req_i.restart);
    end
    fail_cnt_o <= fails;
    pending_o  <= beat_q.size();
  end

endmodule

### test/permutation_enumerator_top_tb.sv
// Testbench top for the permutation enumerator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module permutation_enumerator_top_tb;
  import perm_enum_pkg::*;

  // Request codes carried by the restart field.
  localparam logic RESUME  = 1'b0;
  localparam logic RESTART = 1'b1;

  // The first permutation of length eight alone takes a long search walk, so the
  // limit is set several times above the slowest correct run.
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_CYCLES  = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  perm_enum_in_if  req_if ();
  perm_enum_out_if rsp_if ();

  int fail_cnt;
  int pending;
  int cycle_cnt = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_ticket;
  int hold_seen = 0;
  int hold_left = 0;

  permutation_enumerator_top #(
    .MAX_N(8)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  permutation_enumerator_checker #(
    .MAX_N(8)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung block or a lost result beat ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side. Normally ready drops at random with the current idle rate. When
  // the stimulus bumps hold_ticket, ready stays low for a long stretch so that the
  // block backs up and has to stall the request channel.
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen     <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
      rsp_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request beat and returns at the edge that accepts it. Valid is left
  // high so that back-to-back beats need no second assignment in one time step;
  // an idle gap, when drawn, lowers it first and puts noise on restart.
  task automatic send_req(input logic restart_flag);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'($urandom_range(1));
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart_flag;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // Stops offering and waits until every predicted beat has come back. The first
  // edge is always waited out so the checker has seen the last accepted request.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Length writes only happen with the block idle. Every request produces beats,
  // so once the queue is empty only a short settling tail is needed.
  task automatic write_len(input logic [LEN_W-1:0] len_val);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= len_val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // The length in force when a phase skips its write is whatever was last written;
  // the stimulus tracks it here so that burst sizes stay sensible.
  logic [LEN_W-1:0] last_len;

  always @(posedge clk_i) begin
    if (cfg_we) last_len <= cfg_wdata;
  end

  function automatic logic [LEN_W-1:0] u_len_shadow(input logic [LEN_W-1:0] dflt);
    if (last_len === 'x || last_len > 4'd6) return dflt;
    return last_len;
  endfunction

  initial begin
    int          rand_sent;
    int          burst;
    int          pick;
    int unsigned eff_n;
    logic [LEN_W-1:0] len_val;
    bit          hold_fired;

    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    hold_ticket    <= 0;
    send_idle_pct  <= 30;
    recv_idle_pct  <= 60;
    rand_sent  = 0;
    hold_fired = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Out of reset the length is three and the search stands at its
    // start, so even a plain resume must return the first permutation.
    send_req(RESUME);
    send_req(RESUME);
    send_req(RESTART);
    // Walk the rest of the length-three sequence into exhaustion, then resume once
    // more to see the done beat repeat, and restart out of the done state.
    repeat (6) send_req(RESUME);
    send_req(RESUME);
    send_req(RESTART);

    // A length of zero behaves as one: a single one-element permutation, then done.
    write_len(4'd0);
    send_req(RESUME);
    send_req(RESUME);
    send_req(RESTART);

    // The largest code clamps to eight; overwrite it before any request. A length
    // write in the middle of a sequence must restart the search.
    write_len(4'd15);
    write_len(4'd2);
    send_req(RESUME);
    write_len(4'd2);
    send_req(RESUME);
    send_req(RESUME);
    send_req(RESUME);

    // Full length: one request only, since reaching the first permutation of eight
    // takes a long walk through rejected candidates.
    write_len(4'd8);
    send_req(RESTART);
    drain();

    // Random part. Each phase picks a length (mostly small, so sequences often run
    // to exhaustion) and then issues a run of resumes with an occasional restart.
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent >= (2 * RANDOM_ITEMS) / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (rand_sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct <= 60;
        recv_idle_pct <= 30;
      end

      pick = $urandom_range(99);
      if (pick < 5) len_val = 4'd0;
      else if (pick < 15) len_val = 4'd1;
      else if (pick < 30) len_val = 4'd2;
      else if (pick < 50) len_val = 4'd3;
      else if (pick < 75) len_val = 4'd4;
      else if (pick < 90) len_val = 4'd5;
      else len_val = 4'd6;

      // Most phases write a new length; the others carry on from where the
      // previous phase stopped.
      if ($urandom_range(3) != 0) write_len(len_val);
      else len_val = u_len_shadow(len_val);
      eff_n = (len_val == 0) ? 1 : len_val;

      case (eff_n)
        1:       burst = $urandom_range(1, 5);
        2:       burst = $urandom_range(1, 6);
        3:       burst = $urandom_range(3, 10);
        4:       burst = $urandom_range(5, 30);
        5:       burst = $urandom_range(10, 130);
        default: burst = $urandom_range(5, 25);
      endcase

      // Once, on entering the second idling pattern, the result side holds off
      // while requests keep coming, so the block fills up and stalls its input.
      if (!hold_fired && rand_sent >= RANDOM_ITEMS / 3) begin
        hold_ticket <= hold_ticket + 1;
        hold_fired = 1'b1;
      end

      for (int i = 0; i < burst; i++) begin
        send_req(($urandom_range(99) < 6) ? RESTART : RESUME);
        rand_sent++;
      end
      // The sender pauses here until every expected beat has come back.
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
